// ----- sv/pidsaw_pkg.sv -----
// pidsaw_pkg: shared types, codes and defaults for the pid step controller
// no dependencies
`timescale 1ns / 1ps
package pidsaw_pkg;

    localparam int QW              = 32;
    localparam int MW              = 34;
    localparam int PW              = 68;
    localparam int WW              = 70;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd7;

    localparam logic [30:0] TS_RST    = 31'd655;
    localparam logic [17:0] BETA_RST  = 18'd53620;
    localparam logic [30:0] SCALE_RST = 31'd65536;

    typedef enum logic [1:0] {
        CMD_FILT  = 2'd0,
        CMD_RATE  = 2'd1,
        CMD_SCHED = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_TRAP_MUL, S_TRAP_ACC, S_SS_MUL, S_SS_ACC, S_SC_MUL, S_SC_ACC,
        S_Q_START, S_Q_WAIT, S_B_MUL, S_B_ACC, S_NB_MUL, S_NB_ACC,
        S_KP_MUL, S_KP_ACC, S_KD_MUL, S_KD_ACC, S_PD_START, S_PD_WAIT,
        S_KI_MUL, S_KI_ACC, S_I_START, S_I_WAIT, S_CLAMP,
        S_BC_MUL, S_BC_ACC, S_BC_START, S_BC_WAIT, S_FIN
    } t_state;

    typedef logic signed [MW-1:0] t_mop;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [WW-1:0] t_wide;

endpackage

// ----- sv/pidsaw_ifs.sv -----
// pidsaw_ifs: request and result channel interfaces of the pid step controller
// depends on nothing
`timescale 1ns / 1ps
interface pidsaw_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic signed [31:0] measured_rate;
    logic signed [31:0] speed;
    modport source (output valid, command, setpoint, measured, measured_rate, speed,
                    input ready);
    modport sink   (input valid, command, setpoint, measured, measured_rate, speed,
                    output ready);
endinterface

interface pidsaw_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               clamped;
    logic               fault;
    modport source (output valid, drive, clamped, fault, input ready);
    modport sink   (input valid, drive, clamped, fault, output ready);
endinterface

// ----- sv/pidsaw_div.sv -----
// pidsaw_div: iterative fixed point divider, one quotient bit per cycle, saturating
// depends on pidsaw_pkg
`timescale 1ns / 1ps
module pidsaw_div #(
    parameter int FRAC_BITS = pidsaw_pkg::FRAC_BITS_DEF,
    parameter int SAT_W     = pidsaw_pkg::QW
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [pidsaw_pkg::QW-1:0] i_num,
    input  logic signed [pidsaw_pkg::QW-1:0] i_den,
    output logic                             o_done,
    output logic signed [pidsaw_pkg::QW-1:0] o_quot
);
    import pidsaw_pkg::*;

    localparam int CW = $clog2(QW + 1);
    localparam logic [QW:0]   MAG_HI = (33'd1 << (SAT_W - 1)) - 33'd1;
    localparam logic [QW:0]   MAG_LO = 33'd1 << (SAT_W - 1);
    localparam logic [QW-1:0] Q_HI   = MAG_HI[QW-1:0];
    localparam logic [QW-1:0] Q_LO   = QW'(-(34'sd1 <<< (SAT_W - 1)));

    logic          r_busy, r_done, r_neg, r_ovf;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_rem, r_low, r_den, r_mag;
    logic [QW-1:0] w_ua, w_ub, w_hi;
    logic [QW:0]   w_rem2;
    logic          w_ge;

    assign w_ua   = i_num[QW-1] ? QW'(-i_num) : QW'(i_num);
    assign w_ub   = i_den[QW-1] ? QW'(-i_den) : QW'(i_den);
    assign w_hi   = w_ua >> (QW - FRAC_BITS);
    assign w_rem2 = {r_rem, r_low[QW-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_num[QW-1] ^ i_den[QW-1];
                r_den <= w_ub;
                r_rem <= w_hi;
                r_low <= w_ua << FRAC_BITS;
                r_mag <= '0;
                r_cnt <= CW'(QW);
                if (w_hi >= w_ub) begin
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_ovf  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? QW'(w_rem2 - {1'b0, r_den}) : w_rem2[QW-1:0];
                r_low <= r_low << 1;
                r_mag <= {r_mag[QW-2:0], w_ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_quot = r_neg ? Q_LO : Q_HI;
        end else if (!r_neg) begin
            o_quot = ({1'b0, r_mag} > MAG_HI) ? Q_HI : r_mag;
        end else begin
            o_quot = ({1'b0, r_mag} > MAG_LO) ? Q_LO : QW'(-r_mag);
        end
    end

    assign o_done = r_done;

endmodule

// ----- sv/pid_step_antiwindup_top.sv -----
// pid_step_antiwindup_top: pid step with filtered derivative, scheduling and anti-windup
// depends on pidsaw_pkg, pidsaw_ifs and pidsaw_div
//
//   channel   dir  payload                                             handshake
//   i_in_ch   in   command, setpoint, measured, measured_rate, speed   valid/ready
//   o_out_ch  out  drive, clamped, fault                               valid/ready
//   i_cfg_*   in   index 0..7, 32 bit data                             write enable
//
// one request at a time through one shared multiplier and one radix-2 divider
// command 1 runs no divide, command 0 at most one (one 32 step divide), command 3 only the finish step
// command 2 up to three divides on the same divider, none when its divisor is zero
// synchronous active low reset clears state and both channels and loads the config defaults
// a waiting result does not block the next request; the finish step waits for it
`timescale 1ns / 1ps
module pid_step_antiwindup_top #(
    parameter int DATA_WIDTH = pidsaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidsaw_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    pidsaw_in_if.sink                               i_in_ch,
    pidsaw_out_if.source                            o_out_ch,
    input  logic                                    i_cfg_we,
    input  logic [pidsaw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pidsaw_pkg::QW-1:0]               i_cfg_data
);
    import pidsaw_pkg::*;

    localparam int    SAT_W     = (DATA_WIDTH < QW) ? DATA_WIDTH : QW;
    localparam t_wide SAT_HI    = (t_wide'(1) <<< (SAT_W - 1)) - t_wide'(1);
    localparam t_wide SAT_LO    = -SAT_HI - t_wide'(1);
    localparam logic [QW:0] RATE_GATE = 33'(((64'd8 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam t_mop  ONE_Q     = t_mop'(1) <<< FRAC_BITS;

    t_state r_state, n_state;

    logic signed [QW-1:0] r_kp, r_ki, r_kd, r_low, r_high;
    logic [30:0]          r_ts, r_scale;
    logic signed [17:0]   r_beta;

    logic signed [QW-1:0] r_integ, r_filt, r_pmeas, r_perr;
    t_cmd                 r_cmd;
    logic signed [QW-1:0] r_e, r_x, r_rate, r_spd, r_t, r_u, r_div, r_pd, r_force;
    logic signed [QW-1:0] r_drive;
    logic                 r_clamped, r_fault;
    t_prod                r_prod;

    logic                 r_ov;
    logic signed [QW-1:0] r_o_drive;
    logic                 r_o_clamped, r_o_fault;

    t_mop                 w_ma, w_mb;
    logic signed [QW-1:0] w_mulq, w_trap, w_e, w_dnum, w_dden, w_quot, w_lim;
    logic                 w_dstart, w_ddone, w_acc, w_gate, w_hi_v, w_lo_v, w_zero_i;
    logic [QW:0]          w_fabs;

    function automatic logic signed [QW-1:0] f_sat(input t_wide x);
        if (x > SAT_HI) begin
            return SAT_HI[QW-1:0];
        end else if (x < SAT_LO) begin
            return SAT_LO[QW-1:0];
        end
        return x[QW-1:0];
    endfunction

    assign i_in_ch.ready     = (r_state == S_IDLE);
    assign w_acc             = i_in_ch.valid && i_in_ch.ready;
    assign w_e               = f_sat(t_wide'(i_in_ch.setpoint) - t_wide'(i_in_ch.measured));
    assign w_fabs            = r_filt[QW-1] ? 33'(-t_wide'(r_filt)) : 33'(t_wide'(r_filt));
    assign w_gate            = w_fabs < RATE_GATE;
    assign w_mulq            = f_sat(t_wide'(r_prod >>> FRAC_BITS));
    assign w_trap            = f_sat(t_wide'(r_integ) + t_wide'(r_prod >>> (FRAC_BITS + 1)));
    assign w_hi_v            = r_force > r_high;
    assign w_lo_v            = r_force < r_low;
    assign w_lim             = w_hi_v ? r_high : r_low;
    assign w_zero_i          = (w_hi_v ? (r_pd > w_lim) : (r_pd < w_lim)) || (r_ki == '0);

    assign o_out_ch.valid    = r_ov;
    assign o_out_ch.drive    = r_o_drive;
    assign o_out_ch.clamped  = r_o_clamped;
    assign o_out_ch.fault    = r_o_fault;

    pidsaw_div #(
        .FRAC_BITS (FRAC_BITS),
        .SAT_W     (SAT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (t_cmd'(i_in_ch.command))
                        CMD_FILT:  n_state = w_gate ? S_TRAP_MUL : S_Q_START;
                        CMD_RATE:  n_state = S_TRAP_MUL;
                        CMD_SCHED: n_state = S_SS_MUL;
                        CMD_CLEAR: n_state = S_FIN;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_TRAP_MUL: n_state = S_TRAP_ACC;
            S_TRAP_ACC: n_state = (r_cmd == CMD_FILT) ? S_Q_START : S_KP_MUL;
            S_SS_MUL:   n_state = S_SS_ACC;
            S_SS_ACC:   n_state = S_SC_MUL;
            S_SC_MUL:   n_state = S_SC_ACC;
            S_SC_ACC:   n_state = (w_mulq == '0) ? S_FIN : S_TRAP_MUL;
            S_Q_START:  n_state = (r_ts == '0) ? S_B_MUL : S_Q_WAIT;
            S_Q_WAIT:   n_state = w_ddone ? S_B_MUL : S_Q_WAIT;
            S_B_MUL:    n_state = S_B_ACC;
            S_B_ACC:    n_state = S_NB_MUL;
            S_NB_MUL:   n_state = S_NB_ACC;
            S_NB_ACC:   n_state = S_KP_MUL;
            S_KP_MUL:   n_state = S_KP_ACC;
            S_KP_ACC:   n_state = S_KD_MUL;
            S_KD_MUL:   n_state = S_KD_ACC;
            S_KD_ACC:   n_state = (r_cmd == CMD_SCHED) ? S_PD_START : S_KI_MUL;
            S_PD_START: n_state = S_PD_WAIT;
            S_PD_WAIT:  n_state = w_ddone ? S_KI_MUL : S_PD_WAIT;
            S_KI_MUL:   n_state = S_KI_ACC;
            S_KI_ACC:   n_state = (r_cmd == CMD_SCHED) ? S_I_START : S_CLAMP;
            S_I_START:  n_state = S_I_WAIT;
            S_I_WAIT:   n_state = w_ddone ? S_CLAMP : S_I_WAIT;
            S_CLAMP: begin
                if ((r_cmd == CMD_SCHED) && (w_hi_v || w_lo_v) && !w_zero_i) begin
                    n_state = S_BC_MUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_BC_MUL:   n_state = S_BC_ACC;
            S_BC_ACC:   n_state = S_BC_START;
            S_BC_START: n_state = S_BC_WAIT;
            S_BC_WAIT:  n_state = w_ddone ? S_FIN : S_BC_WAIT;
            S_FIN:      n_state = (!r_ov || o_out_ch.ready) ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    // shared multiplier and divider operands
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_dstart = 1'b0;
        w_dnum   = r_t;
        w_dden   = r_div;
        unique case (r_state)
            S_TRAP_MUL: begin
                w_ma = t_mop'(r_e) + t_mop'(r_perr);
                w_mb = t_mop'($signed({1'b0, r_ts}));
            end
            S_SS_MUL: begin
                w_ma = t_mop'(r_spd);
                w_mb = t_mop'(r_spd);
            end
            S_SC_MUL: begin
                w_ma = t_mop'(r_t);
                w_mb = t_mop'($signed({1'b0, r_scale}));
            end
            S_B_MUL: begin
                w_ma = t_mop'(r_beta);
                w_mb = t_mop'(r_filt);
            end
            S_NB_MUL: begin
                w_ma = ONE_Q - t_mop'(r_beta);
                w_mb = t_mop'(r_t);
            end
            S_KP_MUL: begin
                w_ma = t_mop'(r_kp);
                w_mb = t_mop'(r_e);
            end
            S_KD_MUL: begin
                w_ma = t_mop'(r_kd);
                w_mb = (r_cmd == CMD_FILT) ? t_mop'(r_filt) : t_mop'(r_rate);
            end
            S_KI_MUL: begin
                w_ma = t_mop'(r_ki);
                w_mb = t_mop'(r_integ);
            end
            S_BC_MUL: begin
                w_ma = t_mop'(r_t);
                w_mb = t_mop'(r_div);
            end
            S_Q_START: begin
                w_dstart = (r_ts != '0);
                w_dnum   = f_sat(t_wide'(r_x) - t_wide'(r_pmeas));
                w_dden   = $signed({1'b0, r_ts});
            end
            S_PD_START: begin
                w_dstart = 1'b1;
                w_dnum   = f_sat(t_wide'(r_t) - t_wide'(r_u));
            end
            S_I_START: begin
                w_dstart = 1'b1;
            end
            S_BC_START: begin
                w_dstart = 1'b1;
                w_dden   = r_ki;
            end
            default: begin
                w_dstart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_low   <= '0;
            r_high  <= '0;
            r_ts    <= TS_RST;
            r_beta  <= BETA_RST;
            r_scale <= SCALE_RST;
            r_integ <= '0;
            r_filt  <= '0;
            r_pmeas <= '0;
            r_perr  <= '0;
            r_ov    <= 1'b0;
            r_cmd   <= CMD_FILT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KP:    r_kp    <= i_cfg_data;
                    CFG_KI:    r_ki    <= i_cfg_data;
                    CFG_KD:    r_kd    <= i_cfg_data;
                    CFG_LOW:   r_low   <= i_cfg_data;
                    CFG_HIGH:  r_high  <= i_cfg_data;
                    CFG_TS:    r_ts    <= i_cfg_data[30:0];
                    CFG_BETA:  r_beta  <= i_cfg_data[17:0];
                    CFG_SCALE: r_scale <= i_cfg_data[30:0];
                    default:   r_kp    <= r_kp;
                endcase
            end
            if (o_out_ch.ready && (r_state != S_FIN)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_cmd     <= t_cmd'(i_in_ch.command);
                        r_e       <= w_e;
                        r_x       <= i_in_ch.measured;
                        r_rate    <= i_in_ch.measured_rate;
                        r_spd     <= i_in_ch.speed;
                        r_drive   <= '0;
                        r_clamped <= 1'b0;
                        r_fault   <= 1'b0;
                        if (t_cmd'(i_in_ch.command) == CMD_CLEAR) begin
                            r_integ <= '0;
                        end
                    end
                end
                S_TRAP_ACC: r_integ <= w_trap;
                S_SS_ACC:   r_t     <= w_mulq;
                S_SC_ACC: begin
                    r_div   <= w_mulq;
                    r_fault <= (w_mulq == '0);
                end
                S_Q_START: begin
                    if (r_ts == '0) begin
                        r_t <= '0;
                    end
                end
                S_Q_WAIT: begin
                    if (w_ddone) begin
                        r_t <= w_quot;
                    end
                end
                S_B_ACC:    r_u <= w_mulq;
                S_NB_ACC: begin
                    r_filt  <= f_sat(t_wide'(r_u) + t_wide'(w_mulq));
                    r_pmeas <= r_x;
                end
                S_KP_ACC:   r_t <= w_mulq;
                S_KD_ACC:   r_u <= w_mulq;
                S_PD_WAIT: begin
                    if (w_ddone) begin
                        r_pd <= w_quot;
                    end
                end
                S_KI_ACC: begin
                    if (r_cmd == CMD_SCHED) begin
                        r_t <= w_mulq;
                    end else begin
                        r_force <= f_sat(t_wide'(f_sat(t_wide'(r_t) + t_wide'(w_mulq)))
                                         - t_wide'(r_u));
                    end
                end
                S_I_WAIT: begin
                    if (w_ddone) begin
                        r_force <= f_sat(t_wide'(r_pd) + t_wide'(w_quot));
                    end
                end
                S_CLAMP: begin
                    r_drive   <= (w_hi_v || w_lo_v) ? w_lim : r_force;
                    r_clamped <= w_hi_v || w_lo_v;
                    r_perr    <= r_e;
                    r_t       <= f_sat(t_wide'(w_lim) - t_wide'(r_pd));
                    if ((r_cmd == CMD_SCHED) && (w_hi_v || w_lo_v) && w_zero_i) begin
                        r_integ <= '0;
                    end
                end
                S_BC_ACC:   r_t <= w_mulq;
                S_BC_WAIT: begin
                    if (w_ddone) begin
                        r_integ <= w_quot;
                    end
                end
                S_FIN: begin
                    if (!r_ov || o_out_ch.ready) begin
                        r_ov        <= 1'b1;
                        r_o_drive   <= r_drive;
                        r_o_clamped <= r_clamped;
                        r_o_fault   <= r_fault;
                    end
                end
                default: begin
                    r_t <= r_t;
                end
            endcase
        end
    end

endmodule

// ----- sv/pidsaw_chk.sv -----
// pidsaw_chk: port level checks of the pid step controller, bound to the top level
// depends on pid_step_antiwindup_top
`timescale 1ns / 1ps
module pidsaw_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_drive,
    input logic               i_clamped,
    input logic               i_fault
);

    // one request in flight at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_drive) && $stable(i_clamped) && $stable(i_fault)))
        else $error("stalled result changed");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_fault) |-> ((i_drive == 32'sd0) && !i_clamped))
        else $error("fault result carries drive");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind pid_step_antiwindup_top pidsaw_chk u_pidsaw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_drive     (o_out_ch.drive),
    .i_clamped   (o_out_ch.clamped),
    .i_fault     (o_out_ch.fault)
);

// ----- test/pidsaw_checker.sv -----
// pidsaw_checker: predicts every pid step result and compares it with the dut output
// depends on pidsaw_pkg and pidsaw_ifs
`timescale 1ns / 1ps
module pidsaw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pidsaw_in_if                            in_ch,
    pidsaw_out_if                           out_ch,
    input  logic                            i_cfg_we,
    input  logic [pidsaw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pidsaw_pkg::QW-1:0]       i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    import pidsaw_pkg::*;

    typedef logic signed [127:0] t_big;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clamped;
        logic               fault;
    } t_step_out;

    localparam longint RATE_GATE = ((64'sd8 <<< FRAC_BITS_DEF) + 50) / 100;
    localparam longint ONE_Q     = 64'sd1 <<< FRAC_BITS_DEF;

    longint kp, ki, kd, lim_lo, lim_hi, ts, beta, scale;
    longint acc, frate, last_meas, last_err;
    t_step_out steps_due[$];

    function automatic longint sat32(t_big x);
        if (x > 128'sd2147483647) return 64'sd2147483647;
        if (x < -128'sd2147483648) return -64'sd2147483648;
        return longint'(x);
    endfunction

    function automatic t_big mul_floor(t_big a, t_big b, int s);
        return (a * b) >>> s;
    endfunction

    function automatic longint mulq(longint a, longint b);
        return sat32(mul_floor(a, b, FRAC_BITS_DEF));
    endfunction

    function automatic longint divq(longint a, longint b);
        logic [127:0] ua, ub, q, r, mag;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -t_big'(a) : t_big'(a);
        ub = (b < 0) ? -t_big'(b) : t_big'(b);
        q = ua / ub;
        r = ua % ub;
        if (q >= (128'd1 << (40 - FRAC_BITS_DEF))) mag = 128'd1 << 40;
        else mag = (q << FRAC_BITS_DEF) + ((r << FRAC_BITS_DEF) / ub);
        return sat32(neg ? -t_big'(mag) : t_big'(mag));
    endfunction

    function automatic longint trap_acc(longint e);
        return sat32(t_big'(acc) + mul_floor(ts, t_big'(e) + last_err, FRAC_BITS_DEF + 1));
    endfunction

    function automatic t_step_out pid_step(t_cmd cmd, longint sp, longint x, longint rate,
                                           longint spd);
        t_step_out res;
        longint    e, ctl, drv, div, pd, lim, q, d, mag;
        logic      hi_side;
        e = sat32(t_big'(sp) - x);
        drv = 0;
        res.clamped = 1'b0;
        res.fault = 1'b0;
        if (cmd == CMD_CLEAR) begin
            acc = 0;
        end else if (cmd == CMD_SCHED) begin
            div = mulq(mulq(spd, spd), scale);
            if (div == 0) begin
                res.fault = 1'b1;
            end else begin
                acc = trap_acc(e);
                pd = divq(sat32(t_big'(mulq(kp, e)) - mulq(kd, rate)), div);
                ctl = sat32(t_big'(pd) + divq(mulq(ki, acc), div));
                if (ctl > lim_hi || ctl < lim_lo) begin
                    hi_side = ctl > lim_hi;
                    lim = hi_side ? lim_hi : lim_lo;
                    drv = lim;
                    res.clamped = 1'b1;
                    if ((hi_side ? pd > lim : pd < lim) || ki == 0) acc = 0;
                    else acc = divq(mulq(sat32(t_big'(lim) - pd), div), ki);
                end else begin
                    drv = ctl;
                end
                last_err = e;
            end
        end else begin
            if (cmd == CMD_FILT) begin
                mag = frate < 0 ? -frate : frate;
                q = 0;
                if (mag < RATE_GATE) acc = trap_acc(e);
                if (ts != 0) q = divq(sat32(t_big'(x) - last_meas), ts);
                frate = sat32(t_big'(mulq(beta, frate)) + mulq(ONE_Q - beta, q));
                d = frate;
                last_meas = x;
            end else begin
                acc = trap_acc(e);
                d = rate;
            end
            ctl = sat32(t_big'(sat32(t_big'(mulq(kp, e)) + mulq(ki, acc))) - mulq(kd, d));
            if (ctl > lim_hi) begin
                drv = lim_hi;
                res.clamped = 1'b1;
            end else if (ctl < lim_lo) begin
                drv = lim_lo;
                res.clamped = 1'b1;
            end else begin
                drv = ctl;
            end
            last_err = e;
        end
        res.drive = drv[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_step_out got, want;
        if (!i_rst_n) begin
            kp = 0; ki = 0; kd = 0; lim_lo = 0; lim_hi = 0;
            ts = TS_RST; beta = longint'(signed'(BETA_RST)); scale = SCALE_RST;
            acc = 0; frate = 0; last_meas = 0; last_err = 0;
            steps_due.delete();
            o_errors = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:    kp = longint'(signed'(i_cfg_data));
                    CFG_KI:    ki = longint'(signed'(i_cfg_data));
                    CFG_KD:    kd = longint'(signed'(i_cfg_data));
                    CFG_LOW:   lim_lo = longint'(signed'(i_cfg_data));
                    CFG_HIGH:  lim_hi = longint'(signed'(i_cfg_data));
                    CFG_TS:    ts = longint'(i_cfg_data[30:0]);
                    CFG_BETA:  beta = longint'(signed'(i_cfg_data[17:0]));
                    CFG_SCALE: scale = longint'(i_cfg_data[30:0]);
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.drive = out_ch.drive;
                got.clamped = out_ch.clamped;
                got.fault = out_ch.fault;
                if (steps_due.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h %b %b",
                             $time, got.drive, got.clamped, got.fault);
                    o_errors++;
                end else begin
                    want = steps_due.pop_front();
                    if (got.drive !== want.drive) begin
                        $display("%0t drive mismatch: expected %h, actual %h",
                                 $time, want.drive, got.drive);
                        o_errors++;
                    end
                    if (got.clamped !== want.clamped) begin
                        $display("%0t clamped mismatch: expected %b, actual %b",
                                 $time, want.clamped, got.clamped);
                        o_errors++;
                    end
                    if (got.fault !== want.fault) begin
                        $display("%0t fault mismatch: expected %b, actual %b",
                                 $time, want.fault, got.fault);
                        o_errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                steps_due.push_back(pid_step(t_cmd'(in_ch.command),
                                             longint'(in_ch.setpoint),
                                             longint'(in_ch.measured),
                                             longint'(in_ch.measured_rate),
                                             longint'(in_ch.speed)));
            o_pending = steps_due.size();
        end
    end

endmodule

// ----- test/tb_pid_step_antiwindup_top.sv -----
// tb_pid_step_antiwindup_top: stimulus, config phases and verdict for the pid step block
// depends on pidsaw_pkg, pidsaw_ifs, pidsaw_checker and pid_step_antiwindup_top
`timescale 1ns / 1ps
module tb_pid_step_antiwindup_top;
    import pidsaw_pkg::*;

    localparam int  ITEMS_PER_PHASE = 280;
    localparam int  NUM_PHASES      = 6;
    localparam int  DRAIN_CYCLES    = 200;
    localparam longint CYCLE_LIMIT  = 3000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [QW-1:0]        i_cfg_data;
    int                   errors;
    int                   pending;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    bit                   hold_req;
    longint               cycles;

    pidsaw_in_if  in_ch ();
    pidsaw_out_if out_ch ();

    pid_step_antiwindup_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    pidsaw_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, with one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return $urandom;
            3: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic [31:0] rnd_speed();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
            default: return 32'($signed($urandom_range(1 << 15, 1 << 19)))
                            * (($urandom_range(0, 1)) ? 1 : -1);
        endcase
    endfunction

    task automatic send_req(t_cmd cmd, logic [31:0] sp, logic [31:0] x, logic [31:0] rate,
                            logic [31:0] spd);
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.setpoint <= sp;
        in_ch.measured <= x;
        in_ch.measured_rate <= rate;
        in_ch.speed <= spd;
        do @(posedge i_clk); while (!in_ch.ready);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic phase_cfg(int ph);
        logic [31:0] v [8];
        int          b;
        v[0] = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        v[1] = 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        v[2] = 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
        v[3] = -32'($urandom_range(1 << 16, 1 << 22));
        v[4] = 32'($urandom_range(1 << 16, 1 << 22));
        v[5] = 32'($urandom_range(1, 1 << 14));
        b = $urandom_range(0, 1 << 17) - (1 << 16);
        v[6] = 32'(b);
        v[7] = 32'($urandom_range(1 << 12, 1 << 18));
        case (ph)
            1: begin
                v[0] = 32'h7fffffff; v[1] = 32'h80000000; v[2] = 32'h7fffffff;
                v[3] = 32'h80000000; v[4] = 32'h7fffffff; v[5] = 32'h7fffffff;
                v[6] = 32'(-65536); v[7] = 32'h7fffffff;
            end
            2: begin
                v[1] = 32'd0; v[3] = 32'd1000; v[4] = -32'd1000;
                v[5] = 32'd0; v[6] = 32'd65536; v[7] = 32'd0;
            end
            3: begin
                v[0] = $urandom; v[1] = $urandom; v[2] = $urandom;
                v[3] = $urandom; v[4] = $urandom; v[5] = {1'b0, $urandom_range(0, 1) ? 31'd1
                                                       : 31'($urandom)};
                v[6] = 32'($signed(18'($urandom))); v[7] = {1'b0, 31'($urandom)};
            end
            4: begin
                v[0] = 32'h80000000; v[1] = 32'h7fffffff; v[2] = 32'h80000000;
                v[3] = 32'h7fffffff; v[4] = 32'h80000000; v[5] = 32'd1;
                v[6] = 32'($signed(18'h20000)); v[7] = 32'd1;
            end
            default: ;
        endcase
        write_cfg(v);
    endtask

    initial begin
        logic [31:0] v [8];
        t_cmd        cmd;
        int          k;
        in_ch.valid <= 1'b0;
        in_ch.command <= CMD_FILT;
        in_ch.setpoint <= '0;
        in_ch.measured <= '0;
        in_ch.measured_rate <= '0;
        in_ch.speed <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // a few requests on reset config, then directed corners
        send_req(CMD_FILT, 32'h00010000, 32'd0, 32'd0, 32'd0);
        send_req(CMD_SCHED, 32'h00010000, 32'd0, 32'd0, 32'h00010000);
        v = '{32'h00010000, 32'h00008000, 32'h00004000, 32'hfff00000, 32'h00100000,
              32'd655, 32'd53620, 32'd65536};
        drain();
        write_cfg(v);
        send_req(CMD_FILT, 32'h7fffffff, 32'h80000000, 32'd0, 32'd0);
        send_req(CMD_FILT, 32'h80000000, 32'h7fffffff, 32'd0, 32'd0);
        send_req(CMD_FILT, 32'h00001000, 32'h00000100, 32'd0, 32'd0);
        send_req(CMD_FILT, 32'h00001000, 32'h00001000, 32'd0, 32'd0);
        send_req(CMD_RATE, 32'h00020000, 32'h00010000, 32'h7fffffff, 32'd0);
        send_req(CMD_RATE, 32'h00020000, 32'h00010000, 32'h80000000, 32'd0);
        send_req(CMD_RATE, 32'hffff0000, 32'h00000000, 32'd0, 32'd0);
        send_req(CMD_SCHED, 32'h00010000, 32'd0, 32'h00001000, 32'd0);
        send_req(CMD_SCHED, 32'h00010000, 32'd0, 32'h00001000, 32'h00000010);
        send_req(CMD_SCHED, 32'h00010000, 32'd0, 32'h00001000, 32'h00010000);
        send_req(CMD_SCHED, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h00008000);
        send_req(CMD_SCHED, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_req(CMD_SCHED, 32'h00400000, 32'd0, 32'd0, 32'h7fffffff);
        send_req(CMD_CLEAR, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_req(CMD_FILT, 32'd0, 32'h00100000, 32'd0, 32'd0);
        send_req(CMD_FILT, 32'h00010000, 32'h00100000, 32'd0, 32'd0);
        drain();
        // swapped limits, zero period and zero integral gain
        v = '{32'h00010000, 32'd0, 32'h00010000, 32'h00010000, 32'hffff0000,
              32'd0, 32'd65536, 32'd65536};
        write_cfg(v);
        send_req(CMD_FILT, 32'h00050000, 32'd0, 32'd0, 32'd0);
        send_req(CMD_FILT, 32'hfffb0000, 32'd0, 32'd0, 32'd0);
        send_req(CMD_FILT, 32'd0, 32'd0, 32'd0, 32'd0);
        send_req(CMD_SCHED, 32'h00050000, 32'd0, 32'd0, 32'h00010000);
        send_req(CMD_SCHED, 32'hfffb0000, 32'd0, 32'd0, 32'h00010000);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            phase_cfg(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 40) hold_req = 1'b1;
                k = $urandom_range(0, 99);
                cmd = (k < 35) ? CMD_FILT : (k < 60) ? CMD_RATE : (k < 94) ? CMD_SCHED
                                                                           : CMD_CLEAR;
                send_req(cmd, rnd_val(), rnd_val(), rnd_val(), rnd_speed());
            end
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
